### hw/rtl/bds_pkg.sv
// Shared types and constants for the 2x2 box downscaler.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

	// Image geometry limits.
	localparam int MAX_WIDTH  = 4096;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 13;
	localparam int PIX_W      = 8;
	localparam int PAIR_W     = PIX_W + 1;

	// Command queue depth between front and back.
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// What the back end does with one pair sum.
	typedef enum logic {
		CMD_STORE = 1'b0,
		CMD_EMIT  = 1'b1
	} cmd_kind_t;

	// One command from the front end to the back end.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [PAIR_W-1:0]  pair;
		logic               row_end;
		logic               frame_end;
	} cmd_t;

endpackage

`default_nettype wire

### hw/rtl/bds_front.sv
// Front end: tracks the pixel position, forms pair sums and issues line commands.
`timescale 1ns / 1ps
`default_nettype none

module bds_front
	import bds_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
	input  wire logic [DIM_W-1:0]     image_width,
	input  wire logic [DIM_W-1:0]     image_height,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output cmd_t                      push_cmd
);

	logic [COL_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic [PIX_W-1:0]  held_q;

	logic [DIM_W-1:0]  ew;
	logic [DIM_W-1:0]  eh;
	logic [COL_W-1:0]  c;
	logic [DIM_W-1:0]  r;
	logic [DIM_W-1:0]  c_inc;
	logic [DIM_W:0]    r_inc;
	logic [DIM_W:0]    c_plus3;
	logic [DIM_W:0]    r_plus3;
	logic              accept;
	logic              re;

	// Effective geometry: width clamps to one and to the line length, height to one.
	always_comb begin
		if (image_width == '0) begin
			ew = DIM_W'(1);
		end else if (image_width > DIM_W'(MAX_WIDTH)) begin
			ew = DIM_W'(MAX_WIDTH);
		end else begin
			ew = image_width;
		end
		eh = (image_height == '0) ? DIM_W'(1) : image_height;
	end

	// Current position, restarted if the geometry shrank under the counters.
	assign c = ({1'b0, col_q} >= ew) ? '0 : col_q;
	assign r = (row_q >= eh) ? '0 : row_q;

	assign c_inc   = {1'b0, c} + DIM_W'(1);
	assign r_inc   = {1'b0, r} + (DIM_W+1)'(1);
	assign c_plus3 = {2'b00, c} + (DIM_W+1)'(3);
	assign r_plus3 = {1'b0, r} + (DIM_W+1)'(3);

	assign accept   = s_tvalid && s_tready;
	assign s_tready = push_ready;
	assign re       = c_plus3 > {1'b0, ew};

	// A command goes out on every odd column: store on even rows, emit on odd rows.
	always_comb begin
		push_valid         = accept && c[0];
		push_cmd.kind      = r[0] ? CMD_EMIT : CMD_STORE;
		push_cmd.idx       = c[COL_W-1:1];
		push_cmd.pair      = {1'b0, held_q} + {1'b0, s_tdata};
		push_cmd.row_end   = re;
		push_cmd.frame_end = re && (r_plus3 > {1'b0, eh});
	end

	// Position counters and the left pixel of the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (!c[0]) begin
				held_q <= s_tdata;
			end
			if (c_inc >= ew) begin
				col_q <= '0;
				row_q <= (r_inc >= {1'b0, eh}) ? '0 : r_inc[DIM_W-1:0];
			end else begin
				col_q <= c_inc[COL_W-1:0];
				row_q <= r;
			end
		end
	end

	// An issued command always lands in the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("front issued a command while the queue was full");

endmodule

`default_nettype wire

### hw/rtl/bds_queue.sv
// Short command queue decoupling the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module bds_queue
	import bds_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire cmd_t  push_cmd,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output cmd_t       pop_cmd
);

	cmd_t                 entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != (Q_PTR_W+1)'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_PTR_W+1)'(Q_DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + (Q_PTR_W+1)'(1)))
		else $error("queue count missed a push");

endmodule

`default_nettype wire

### hw/rtl/bds_back.sv
// Back end: line store of pair sums, final add and output register.
`timescale 1ns / 1ps
`default_nettype none

module bds_back
	import bds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire cmd_t              cmd,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [PIX_W-1:0]       m_tdata,   // [7:0] pixel_out
	output logic                   m_tlast,   // row_end
	output logic                   m_tuser    // [0] frame_end
);

	logic [PAIR_W-1:0]  line_mem [LINE_DEPTH];

	logic               v_s2;
	logic [PAIR_W-1:0]  above_s2;
	logic [PAIR_W-1:0]  pair_s2;
	logic               re_s2;
	logic               fe_s2;

	logic               out_v_q;
	logic [PIX_W-1:0]   out_pix_q;
	logic               out_re_q;
	logic               out_fe_q;

	logic               out_free;
	logic               s2_free;
	logic               take;
	logic               do_store;
	logic               do_emit;
	logic [PAIR_W:0]    sum;

	assign out_free  = !out_v_q || m_tready;
	assign s2_free   = !v_s2 || out_free;
	assign cmd_ready = (cmd.kind == CMD_STORE) || s2_free;
	assign take      = cmd_valid && cmd_ready;
	assign do_store  = take && (cmd.kind == CMD_STORE);
	assign do_emit   = take && (cmd.kind == CMD_EMIT);
	assign sum       = {1'b0, above_s2} + {1'b0, pair_s2};

	// Line store write: pair sums of the even row.
	always_ff @(posedge clk) begin
		if (do_store) begin
			line_mem[cmd.idx] <= cmd.pair;
		end
	end

	// Line store read and the payload of the second stage.
	always_ff @(posedge clk) begin
		if (do_emit) begin
			above_s2 <= line_mem[cmd.idx];
			pair_s2  <= cmd.pair;
			re_s2    <= cmd.row_end;
			fe_s2    <= cmd.frame_end;
		end
	end

	// Output payload: average of the four pixels.
	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			out_pix_q <= sum[PAIR_W:2];
			out_re_q  <= re_s2;
			out_fe_q  <= fe_s2;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_free) begin
				v_s2 <= do_emit;
			end
			if (out_free) begin
				out_v_q <= v_s2;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_re_q;
	assign m_tuser  = out_fe_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		do_emit |=> v_s2)
		else $error("emit command lost before the second stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("frame end word without row end");

endmodule

`default_nettype wire

### hw/rtl/box_downscale_by_two_top.sv
// Top level of the 2x2 box-filter downscaler.
`timescale 1ns / 1ps
`default_nettype none

// Takes 8-bit grey pixels in row-major order, one word per clock, and emits the
// truncated average of each non-overlapping 2x2 block, so the output image is half
// the size in each direction; an odd last column or row is dropped. The input takes
// one pixel per cycle, sustained, while the output side keeps up; a result passes
// through the queue, line-store read and output register after the pixel that
// completes its block. The front end counts columns and rows and forms pair sums; a
// four-entry command queue feeds the back end, which holds one 2048-entry line of
// pair sums in a single-port memory. The line store needs no clearing after reset.
// m_tlast marks the last pixel of an output row and m_tuser the last of the frame.
// Width and height are written through the cfg port (index 0 width, 1 height, reset
// 640 x 480) by the user only while the block is idle; the block does not enforce it.
module box_downscale_by_two_top
	import bds_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [DIM_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [PIX_W-1:0]           m_tdata,   // [7:0] pixel_out
	output logic                       m_tlast,   // row_end
	output logic                       m_tuser    // [0] frame_end
);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic              push_valid;
	logic              push_ready;
	cmd_t              push_cmd;
	logic              pop_valid;
	logic              pop_ready;
	cmd_t              pop_cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bds_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.image_width  (width_q),
		.image_height (height_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	bds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	bds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire
